// File: sv/binary64_to_minifloat_converter_core_macros.svh
// Assertion macros used by the converter core.
`ifndef BINARY64_TO_MINIFLOAT_CONVERTER_CORE_MACROS_SVH
`define BINARY64_TO_MINIFLOAT_CONVERTER_CORE_MACROS_SVH
// Asserts that a condition implies a consequence on the same clock edge.
`define B2M_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Asserts that a condition implies a consequence on the next clock edge.
`define B2M_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/b2m_pkg.sv
// ----------------------------------------------------------------------------
// b2m_pkg
// Shared types and constants of the binary64 to narrow float converter.
// ----------------------------------------------------------------------------
package b2m_pkg;

	localparam int unsigned SrcMantW = 52;
	localparam int unsigned WordW = 64;

	localparam logic [3:0] EwMin = 4'd2;
	localparam logic [3:0] EwMax = 4'd11;
	localparam logic [5:0] FwMin = 6'd1;
	localparam logic [5:0] FwMax = 6'd52;
	localparam logic [3:0] EwReset = 4'd8;
	localparam logic [5:0] FwReset = 6'd23;

	localparam logic [1:0] RegExpWidth = 2'd0;
	localparam logic [1:0] RegFracWidth = 2'd1;

	// Item class decided in the first stage.
	typedef enum logic [1:0] {
		CLS_FINITE = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_INF    = 2'd2,
		CLS_NAN    = 2'd3
	} cls_t;

	// Stage 1 to stage 2: unpacked, normalized source.
	typedef struct packed {
		logic        sign;
		cls_t        cls;
		logic [52:0] sig;   // normalized, leading one at bit 52
		logic signed [12:0] u; // unbiased exponent of the leading one
		logic [3:0]  ew;
		logic [5:0]  fw;
	} s1_t;

	// Stage 2 to stage 3: shift decided.
	typedef struct packed {
		logic        sign;
		cls_t        cls;
		logic [52:0] sig;
		logic signed [12:0] u;
		logic        normal;
		logic [6:0]  sh;     // right shift amount, 0..127 (saturated)
		logic        left;   // shift is a left shift (sh holds its amount)
		logic signed [12:0] bias;
		logic [3:0]  ew;
		logic [5:0]  fw;
	} s2_t;

	// Stage 3 to stage 4: rounded mantissa.
	typedef struct packed {
		logic        sign;
		cls_t        cls;
		logic [63:0] mant;
		logic        inexact;
		logic        normal;
		logic signed [12:0] u;
		logic signed [12:0] bias;
		logic [3:0]  ew;
		logic [5:0]  fw;
	} s3_t;

endpackage

// File: sv/b2m_unpack.sv
// ----------------------------------------------------------------------------
// b2m_unpack
// Classifies the source and normalizes its significand.
// ----------------------------------------------------------------------------
module b2m_unpack (
	input  logic [63:0]   source_bits,
	input  logic [3:0]    ew,
	input  logic [5:0]    fw,
	output b2m_pkg::s1_t  d
);
	logic [10:0] e64;
	logic [51:0] m64;
	logic [52:0] sig;
	logic [5:0]  lz;
	logic signed [12:0] e2;

	always_comb begin
		e64 = source_bits[62:52];
		m64 = source_bits[51:0];
		sig = (e64 == 11'd0) ? {1'b0, m64} : {1'b1, m64};
		e2 = (e64 == 11'd0) ? -13'sd1074 : ($signed({2'b00, e64}) - 13'sd1075);
		lz = 6'd0;
		for (int i = 0; i < 53; i++) begin
			if (sig[i]) lz = 6'(52 - i);
		end
		d.sign = source_bits[63];
		d.ew = ew;
		d.fw = fw;
		d.sig = sig << lz;
		d.u = e2 + 13'sd52 - $signed({7'd0, lz});
		if (e64 == 11'h7FF) d.cls = (m64 != 52'd0) ? b2m_pkg::CLS_NAN : b2m_pkg::CLS_INF;
		else if (e64 == 11'd0 && m64 == 52'd0) d.cls = b2m_pkg::CLS_ZERO;
		else d.cls = b2m_pkg::CLS_FINITE;
	end
endmodule

// File: sv/b2m_round.sv
// ----------------------------------------------------------------------------
// b2m_round
// Shifts the significand into place and rounds to nearest even.
// ----------------------------------------------------------------------------
module b2m_round (
	input  b2m_pkg::s2_t d,
	output b2m_pkg::s3_t q
);
	logic [116:0] wide;
	logic [63:0]  mant;
	logic [63:0]  rem_mask;
	logic         rbit;
	logic         sticky;

	always_comb begin
		wide = {d.sig, 64'd0} >> d.sh;
		mant = 64'd0;
		rbit = 1'b0;
		sticky = 1'b0;
		rem_mask = 64'd0;
		if (d.left) begin
			mant = 64'(d.sig) << d.sh;
		end else if (d.sh > 7'd60) begin
			sticky = 1'b1;
		end else begin
			mant = 64'(wide[116:64]);
			rbit = wide[63];
			rem_mask = wide[63:0];
			sticky = (wide[62:0] != 63'd0);
			if (rbit && (sticky || mant[0])) mant = mant + 64'd1;
		end
		q.sign = d.sign;
		q.cls = d.cls;
		q.mant = mant;
		q.inexact = d.left ? 1'b0 : (rbit || sticky || (rem_mask != 64'd0));
		q.normal = d.normal;
		q.u = d.u;
		q.bias = d.bias;
		q.ew = d.ew;
		q.fw = d.fw;
	end
endmodule

// File: sv/b2m_pack.sv
// ----------------------------------------------------------------------------
// b2m_pack
// Assembles the target word and applies the special cases.
// ----------------------------------------------------------------------------
module b2m_pack (
	input  b2m_pkg::s3_t d,
	output logic [63:0]  enc,
	output logic         inexact,
	output logic         ovf,
	output logic         bad
);
	logic [63:0] exp_ones;
	logic [63:0] sign_pos;
	logic [63:0] inf_word;
	logic [63:0] word;
	logic [63:0] ebits;

	always_comb begin
		exp_ones = (64'd1 << d.ew) - 64'd1;
		sign_pos = 64'(d.sign) << (7'(d.ew) + 7'(d.fw));
		inf_word = sign_pos | (exp_ones << d.fw);
		enc = 64'd0;
		inexact = 1'b0;
		ovf = 1'b0;
		bad = 1'b0;
		word = 64'd0;
		ebits = 64'(16'(d.u + d.bias - 13'sd1));
		case (d.cls)
			b2m_pkg::CLS_INF: begin
				bad = 1'b1;
				enc = inf_word;
			end
			b2m_pkg::CLS_NAN: begin
				bad = 1'b1;
				enc = inf_word | (64'd1 << (d.fw - 6'd1));
			end
			b2m_pkg::CLS_ZERO: begin
				enc = sign_pos;
			end
			default: begin
				inexact = d.inexact;
				if (d.normal) begin
					if (d.u > d.bias) ovf = 1'b1;
					else begin
						word = (ebits << d.fw) + d.mant;
						if ((word >> d.fw) >= exp_ones) ovf = 1'b1;
					end
				end else begin
					word = d.mant;
				end
				if (ovf) begin
					inexact = 1'b1;
					enc = inf_word;
				end else begin
					enc = word | sign_pos;
				end
			end
		endcase
	end
endmodule

// File: sv/binary64_to_minifloat_converter_core.sv
// Path: each input transfer is registered in r_s1, r_s2 and r_s3 and then in the output register.
// Throughput: one item per cycle while out_stall is low; every stage moves whenever the
// stage after it is empty or moving.
// A stall on the output holds the last stage and every full stage directly behind it;
// a stage with an empty stage after it keeps moving, so bubbles are squeezed out.
// Reset: arst_n clears all valid bits and loads exponent_width 8, fraction_width 23.
// ----------------------------------------------------------------------------
// binary64_to_minifloat_converter_core
// Converts binary64 patterns into a configurable narrow float, rounding to
// nearest with ties to even, through a four-stage pipeline.
// ----------------------------------------------------------------------------
`include "binary64_to_minifloat_converter_core_macros.svh"
module binary64_to_minifloat_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] source_bits,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] encoded_bits,
	output logic        was_inexact,
	output logic        overflowed,
	output logic        bad_input
);
	logic [3:0] exp_width_q;
	logic [5:0] frac_width_q;
	logic [3:0] ew_eff;
	logic [5:0] fw_eff;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// The registers hold the value written; clamping to the legal range
	// happens on the way into the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_width_q <= b2m_pkg::EwReset;
			frac_width_q <= b2m_pkg::FwReset;
		end else if (wr_en) begin
			if (paddr[2] == b2m_pkg::RegExpWidth[0]) exp_width_q <= pwdata[3:0];
			else frac_width_q <= pwdata[5:0];
		end
	end

	always_comb begin
		case (paddr[2])
			b2m_pkg::RegExpWidth[0]: prdata = {28'd0, exp_width_q};
			default: prdata = {26'd0, frac_width_q};
		endcase
	end

	assign ew_eff = (exp_width_q < b2m_pkg::EwMin) ? b2m_pkg::EwMin :
		(exp_width_q > b2m_pkg::EwMax) ? b2m_pkg::EwMax : exp_width_q;
	assign fw_eff = (frac_width_q < b2m_pkg::FwMin) ? b2m_pkg::FwMin :
		(frac_width_q > b2m_pkg::FwMax) ? b2m_pkg::FwMax : frac_width_q;

	// Stage enables: a stage advances when its successor is free or moving.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	b2m_pkg::s1_t d1, r_s1;
	b2m_pkg::s2_t d2, r_s2;
	b2m_pkg::s3_t d3, r_s3;
	logic [63:0] enc_c;
	logic        inx_c, ovf_c, bad_c;

	b2m_unpack u_unpack (.source_bits(source_bits), .ew(ew_eff), .fw(fw_eff), .d(d1));

	// Stage 2: decide normal or subnormal and the shift amount.
	logic signed [12:0] bias, emin, qv, shv;
	logic nrm;
	always_comb begin
		bias = $signed(13'(1) << (r_s1.ew - 4'd1)) - 13'sd1;
		emin = 13'sd1 - bias;
		nrm = (r_s1.u >= emin);
		qv = (nrm ? r_s1.u : emin) - $signed({7'd0, r_s1.fw});
		// Normalized sig has its leading one at bit 52, so e2 = u - 52.
		shv = qv - (r_s1.u - 13'sd52);
		d2.sign = r_s1.sign;
		d2.cls = r_s1.cls;
		d2.sig = r_s1.sig;
		d2.u = r_s1.u;
		d2.normal = nrm;
		d2.left = (shv <= 13'sd0);
		if (shv <= 13'sd0) d2.sh = 7'(-shv);
		else if (shv > 13'sd127) d2.sh = 7'd127;
		else d2.sh = 7'(shv);
		d2.bias = bias;
		d2.ew = r_s1.ew;
		d2.fw = r_s1.fw;
	end

	b2m_round u_round (.d(r_s2), .q(d3));
	b2m_pack u_pack (.d(r_s3), .enc(enc_c), .inexact(inx_c), .ovf(ovf_c), .bad(bad_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) r_s1 <= d1;
		if (en2) r_s2 <= d2;
		if (en3) r_s3 <= d3;
		if (en4) begin
			encoded_bits <= enc_c;
			was_inexact <= inx_c;
			overflowed <= ovf_c;
			bad_input <= bad_c;
		end
	end

	assign out_valid = v_s4;

	`B2M_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && out_stall, out_valid && $stable(encoded_bits), "stalled result changed")
	`B2M_ASSERT_IMPL(a_flags_excl, clk, arst_n, out_valid, !(bad_input && overflowed), "bad input and overflow together")
	`B2M_ASSERT_IMPL(a_ovf_inexact, clk, arst_n, out_valid && overflowed, was_inexact, "overflow without inexact")
	`B2M_ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2 && v_s3 && v_s4, "input stalled with a free stage")
endmodule

// File: test/binary64_to_minifloat_converter_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary64_to_minifloat_converter_core_checker
// Watches both channels and the configuration port of the converter, works
// out the expected narrow float for every input transfer and compares it
// with the output transfers in order.
// ----------------------------------------------------------------------------
module binary64_to_minifloat_converter_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] source_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] encoded_bits,
	input  logic        was_inexact,
	input  logic        overflowed,
	input  logic        bad_input,
	output int          fail_count,
	output int          pending_count
);
	typedef struct packed {
		logic [63:0] word;
		logic        inexact;
		logic        ovf;
		logic        bad;
	} conv_t;

	logic [3:0] exp_bits;
	logic [5:0] frac_bits;
	conv_t      conv_queue[$];

	function automatic conv_t convert(input logic [63:0] src, input logic [3:0] ew_reg,
			input logic [5:0] fw_reg);
		conv_t r;
		int ew, fw, e64, e2, p, u, q, sh, bias, emin;
		logic [63:0] m64, sig, mant, rem, half, ones, sgn, inf_w;
		logic normal;
		ew = (ew_reg < 2) ? 2 : (ew_reg > 11) ? 11 : int'(ew_reg);
		fw = (fw_reg < 1) ? 1 : (fw_reg > 52) ? 52 : int'(fw_reg);
		e64 = int'(src[62:52]);
		m64 = {12'd0, src[51:0]};
		ones = (64'd1 << ew) - 1;
		sgn = {63'd0, src[63]} << (ew + fw);
		inf_w = sgn | (ones << fw);
		r = '0;
		if (e64 == 'h7FF) begin
			r.bad = 1'b1;
			r.word = inf_w;
			if (m64 != 0)
				r.word |= 64'd1 << (fw - 1);
		end else if (e64 == 0 && m64 == 0) begin
			r.word = sgn;
		end else begin
			if (e64 == 0) begin
				sig = m64;
				e2 = -1074;
			end else begin
				sig = m64 | (64'd1 << 52);
				e2 = e64 - 1075;
			end
			p = 52;
			while (p > 0 && sig[p] == 1'b0)
				p--;
			u = p + e2;
			bias = (1 << (ew - 1)) - 1;
			emin = 1 - bias;
			normal = (u >= emin);
			q = normal ? (u - fw) : (emin - fw);
			sh = q - e2;
			if (sh <= 0) begin
				mant = sig << (-sh);
			end else if (sh > 60) begin
				mant = 0;
				r.inexact = 1'b1;
			end else begin
				rem = sig & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				mant = sig >> sh;
				if (rem != 0)
					r.inexact = 1'b1;
				if (rem > half || (rem == half && mant[0]))
					mant++;
			end
			if (normal) begin
				if (u > bias) begin
					r.ovf = 1'b1;
				end else begin
					r.word = (64'(u + bias - 1) << fw) + mant;
					if ((r.word >> fw) >= ones)
						r.ovf = 1'b1;
				end
			end else begin
				r.word = mant;
			end
			if (r.ovf) begin
				r.inexact = 1'b1;
				r.word = inf_w;
			end else begin
				r.word |= sgn;
			end
		end
		return r;
	endfunction

	assign pending_count = conv_queue.size();

	always @(posedge clk or negedge arst_n) begin
		conv_t want;
		if (!arst_n) begin
			exp_bits <= b2m_pkg::EwReset;
			frac_bits <= b2m_pkg::FwReset;
			fail_count <= 0;
			conv_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == b2m_pkg::RegFracWidth[0])
					frac_bits <= pwdata[5:0];
				else
					exp_bits <= pwdata[3:0];
			end
			if (in_valid && !in_stall)
				conv_queue.push_back(convert(source_bits, exp_bits, frac_bits));
			if (out_valid && !out_stall) begin
				if (conv_queue.size() == 0) begin
					$display("%0t: unexpected transfer, actual %h %b%b%b", $time,
						encoded_bits, was_inexact, overflowed, bad_input);
					fail_count <= fail_count + 1;
				end else begin
					want = conv_queue.pop_front();
					if (want != {encoded_bits, was_inexact, overflowed, bad_input}) begin
						$display("%0t: expected %h %b%b%b, actual %h %b%b%b", $time,
							want.word, want.inexact, want.ovf, want.bad, encoded_bits,
							was_inexact, overflowed, bad_input);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: test/binary64_to_minifloat_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary64_to_minifloat_converter_core_tb
// Drives directed and random binary64 patterns through the converter under
// several target formats, with random gaps and output stalls, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module binary64_to_minifloat_converter_core_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] source_bits = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] encoded_bits;
	logic        was_inexact, overflowed, bad_input;
	int          fail_count, pending_count;
	int          cycle_count = 0;
	// Idling is switched off during a quiet stretch in the middle of the run.
	bit          quiet = 1'b0;

	always #2 clk = ~clk;

	binary64_to_minifloat_converter_core u_top (.*);

	binary64_to_minifloat_converter_core_checker u_checker (.*);

	// The output side stalls at random, with a chance of 17 in a hundred, except in the quiet stretch.
	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 17);

	// The watchdog ends a run that hangs; the slowest correct run is far shorter.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// A write has a setup phase and then an access phase; pready is always high.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {index[0], 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One input transfer. The valid stays high between back-to-back items, and
	// random gaps put idle cycles in front of some of them.
	task automatic send(input logic [63:0] value);
		if (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		source_bits <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Settle the pipeline before the configuration changes.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Random patterns weighted toward the exponents that matter to small
	// formats: near one, tiny, huge, subnormal and the special encodings.
	function automatic logic [63:0] random_double();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0, 1, 2: v[62:52] = 11'(32'd1023 + $urandom_range(40) - 32'd20);
			3: v[62:52] = 11'(32'd1023 + $urandom_range(2200) - 32'd1100);
			4: v[62:52] = 11'd0;
			5: v[62:52] = 11'h7FF;
			6: v[40:0] = 41'd0;
			default: ;
		endcase
		return v;
	endfunction

	localparam int NumFormats = 8;
	int ew_list[NumFormats] = '{8, 2, 11, 5, 0, 15, 4, 11};
	int fw_list[NumFormats] = '{23, 1, 52, 10, 0, 63, 3, 1};

	initial begin
		logic [63:0] directed[$];
		directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
			64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0001, 64'h0000_0000_0000_0001,
			64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h3FF8_0000_0000_0000, 64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
			64'h3FFF_FFFF_FFFF_FFFF, 64'h4700_0000_0000_0000, 64'h3800_0000_0000_0000,
			64'h3690_0000_0000_0000, 64'h0010_0000_0000_0000};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send(directed[i]);
		for (int f = 0; f < NumFormats; f++) begin
			drain();
			write_reg(b2m_pkg::RegExpWidth, ew_list[f]);
			write_reg(b2m_pkg::RegFracWidth, fw_list[f]);
			foreach (directed[i])
				send(directed[i]);
			quiet = (f == 3);
			repeat (115)
				send(random_double());
			quiet = 1'b0;
		end
		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+sv
sv/b2m_pkg.sv
sv/b2m_unpack.sv
sv/b2m_round.sv
sv/b2m_pack.sv
sv/binary64_to_minifloat_converter_core.sv
test/binary64_to_minifloat_converter_core_checker.sv
test/binary64_to_minifloat_converter_core_tb.sv
